@@ rtl/core/sems_pkg.sv @@
// Shared constants, codes and interface types of the SLAC EVSE match sequencer.
package sems_pkg;

    // Sum store geometry
    localparam int GROUPS = 58;
    localparam int GIDX_W = 6;
    localparam int SUM_W  = 12;
    localparam logic [GIDX_W:0]   GROUPS_N  = (GIDX_W + 1)'(GROUPS);
    localparam logic [GIDX_W-1:0] GIDX_LAST = GIDX_W'(GROUPS - 1);

    // Field widths
    localparam int CNT_W      = 16;
    localparam int RTY_W      = 3;
    localparam int SND_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_USER_W  = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_USER_W = 2;
    localparam int OUT_DATA_W = 32;

    // Input operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Message kinds of a classified frame
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_PROFILE  = 3'd2;
    localparam logic [2:0] KIND_RESPONSE = 3'd3;
    localparam logic [2:0] KIND_MATCH    = 3'd4;

    // Result actions
    localparam logic [1:0] ACT_STATUS  = 2'd0;
    localparam logic [1:0] ACT_CHAR    = 2'd1;
    localparam logic [1:0] ACT_CONFIRM = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_TO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_TO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RSP_TO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RTY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SND_NEED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_KEY = 3'd7;

    // Matching phases, as reported on the result channel
    typedef enum logic [2:0] {
        PH_WAIT_START = 3'd0,
        PH_SOUNDING   = 3'd1,
        PH_SETTLE     = 3'd2,
        PH_WAIT_RSP   = 3'd3,
        PH_WAIT_MATCH = 3'd4,
        PH_MATCHED    = 3'd5,
        PH_FAILED     = 3'd6
    } sems_phase_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // take the input transfer and read its group sum
        logic exec;     // apply the item and load its result if single
        logic brd;      // read the next characterization entry
        logic bout;     // load the characterization entry into the output
    } sems_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic emit;        // current item sends the characterization
        logic burst_last;  // burst pointer is on the last group
    } sems_sts_t;

endpackage

@@ rtl/core/sems_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sems_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sems_datapath.sv @@
// Datapath: configuration, matching phase and timers, group sum store, result register.
module sems_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [sems_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [sems_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic                              s_tlast,
    input  logic                              cfg_valid,
    input  logic [sems_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sems_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [sems_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [sems_pkg::OUT_USER_W-1:0]   m_tuser,
    output logic                              m_tlast,
    input  sems_pkg::sems_cmd_t               cmd,
    output sems_pkg::sems_sts_t               sts
);
    import sems_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0] start_to_reg, sound_to_reg, settle_reg, rsp_to_reg, match_to_reg;
    logic [RTY_W-1:0] max_rty_reg;
    logic [SND_W-1:0] snd_need_reg;
    logic             fwk_reg;

    // Captured input item
    logic [1:0]        op_reg;
    logic [2:0]        kind_reg;
    logic              ok_reg;
    logic [7:0]        gval_reg;
    logic [GIDX_W-1:0] gidx_reg;
    logic              glast_reg;
    logic              vdone_reg;
    logic              wexp_reg;

    // Matching state
    sems_phase_t       phase_reg, phase_next;
    logic [CNT_W-1:0]  elapsed_reg, elapsed_next;
    logic [RTY_W-1:0]  rty_reg, rty_next;
    logic [SND_W-1:0]  snd_reg, snd_next;
    logic [GROUPS-1:0] valid_reg;
    logic [GIDX_W-1:0] bidx_reg;

    // Sum store access
    logic              ram_re;
    logic [GIDX_W-1:0] ram_raddr;
    logic [SUM_W-1:0]  ram_rdata;
    logic              vld_rd_reg;
    logic [SUM_W-1:0]  sum_rd;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;
    logic              gidx_in_range;

    // Step outcome
    logic [CNT_W-1:0]  el_inc;
    logic [SND_W-1:0]  snd_inc;
    logic              emit;
    logic              wr_en;
    logic              clr;
    logic [1:0]        act;
    logic              wk;

    // Result register
    logic              m_valid_reg;
    logic [1:0]        o_act_reg;
    logic [2:0]        o_phase_reg;
    logic [GIDX_W-1:0] o_idx_reg;
    logic [SUM_W-1:0]  o_sum_reg;
    logic [SND_W-1:0]  o_snd_reg;
    logic              o_last_reg;
    logic              o_wk_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_to_reg <= 16'd400;
            sound_to_reg <= 16'd600;
            settle_reg   <= 16'd45;
            rsp_to_reg   <= 16'd200;
            match_to_reg <= 16'd10000;
            max_rty_reg  <= 3'd2;
            snd_need_reg <= 5'd10;
            fwk_reg      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_TO:  start_to_reg <= cfg_data;
                REG_SOUND_TO:  sound_to_reg <= cfg_data;
                REG_SETTLE:    settle_reg   <= cfg_data;
                REG_RSP_TO:    rsp_to_reg   <= cfg_data;
                REG_MATCH_TO:  match_to_reg <= cfg_data;
                REG_MAX_RTY:   max_rty_reg  <= cfg_data[RTY_W-1:0];
                REG_SND_NEED:  snd_need_reg <= cfg_data[SND_W-1:0];
                REG_FORCE_KEY: fwk_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser[1:0];
            kind_reg  <= s_tuser[4:2];
            ok_reg    <= s_tuser[5];
            gval_reg  <= s_tdata[7:0];
            gidx_reg  <= s_tdata[13:8];
            vdone_reg <= s_tdata[14];
            wexp_reg  <= s_tdata[15];
            glast_reg <= s_tlast;
        end
    end

    // Read the sum store at the incoming group or at the burst pointer
    assign ram_re    = cmd.capture | cmd.brd;
    assign ram_raddr = cmd.brd ? bidx_reg : s_tdata[13:8];

    sems_ram #(
        .WIDTH (SUM_W),
        .DEPTH (GROUPS)
    ) u_sums (
        .aclk  (aclk),
        .we    (cmd.exec & wr_en),
        .waddr (gidx_reg),
        .wdata (sum_sat),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entries never written since restart read as zero
    always_ff @(posedge aclk) begin
        if (ram_re) begin
            vld_rd_reg <= ({1'b0, ram_raddr} < GROUPS_N) && valid_reg[ram_raddr];
        end
    end

    assign sum_rd        = vld_rd_reg ? ram_rdata : '0;
    assign sum_add       = {1'b0, sum_rd} + {{(SUM_W + 1 - 8){1'b0}}, gval_reg};
    assign sum_sat       = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign gidx_in_range = ({1'b0, gidx_reg} < GROUPS_N);

    assign el_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign snd_inc = (snd_reg == '1) ? snd_reg : snd_reg + 1'b1;

    // Work out the effect of the captured item
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        rty_next     = rty_reg;
        snd_next     = snd_reg;
        emit         = 1'b0;
        wr_en        = 1'b0;
        clr          = 1'b0;
        act          = ACT_STATUS;
        wk           = 1'b0;
        case (op_reg)
            OP_RESTART: begin
                phase_next   = PH_WAIT_START;
                elapsed_next = '0;
                rty_next     = '0;
                snd_next     = '0;
                clr          = 1'b1;
            end
            OP_TICK: begin
                if (phase_reg != PH_MATCHED && phase_reg != PH_FAILED) begin
                    elapsed_next = el_inc;
                    unique case (phase_reg)
                        PH_WAIT_START: begin
                            if (el_inc >= start_to_reg) begin
                                phase_next   = PH_FAILED;
                                elapsed_next = '0;
                            end
                        end
                        PH_SOUNDING: begin
                            if (el_inc >= sound_to_reg) begin
                                phase_next   = PH_SETTLE;
                                elapsed_next = '0;
                            end
                        end
                        PH_SETTLE: begin
                            if (el_inc >= settle_reg) begin
                                phase_next   = PH_WAIT_RSP;
                                elapsed_next = '0;
                                emit         = 1'b1;
                            end
                        end
                        PH_WAIT_RSP: begin
                            if (el_inc >= rsp_to_reg) begin
                                elapsed_next = '0;
                                if (rty_reg >= max_rty_reg) begin
                                    phase_next = PH_FAILED;
                                end else begin
                                    rty_next = rty_reg + 1'b1;
                                    emit     = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // wait for the match request
                            if (el_inc >= match_to_reg || (vdone_reg && wexp_reg)) begin
                                phase_next   = PH_FAILED;
                                elapsed_next = '0;
                            end
                        end
                    endcase
                end
            end
            OP_FRAME: begin
                if (ok_reg) begin
                    if (phase_reg == PH_WAIT_START && kind_reg == KIND_START) begin
                        if (elapsed_reg < start_to_reg) begin
                            phase_next   = PH_SOUNDING;
                            elapsed_next = '0;
                        end
                    end else if (phase_reg == PH_SOUNDING && kind_reg == KIND_PROFILE) begin
                        wr_en = gidx_in_range;
                        if (glast_reg) begin
                            snd_next = snd_inc;
                            if (snd_inc >= snd_need_reg) begin
                                phase_next   = PH_SETTLE;
                                elapsed_next = '0;
                            end
                        end
                    end else if (phase_reg == PH_WAIT_RSP && kind_reg == KIND_RESPONSE) begin
                        phase_next   = PH_WAIT_MATCH;
                        elapsed_next = '0;
                    end else if (phase_reg == PH_WAIT_MATCH && kind_reg == KIND_MATCH) begin
                        phase_next   = PH_MATCHED;
                        elapsed_next = '0;
                        act          = ACT_CONFIRM;
                        wk           = fwk_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // Advance the matching state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WAIT_START;
            elapsed_reg <= '0;
            rty_reg     <= '0;
            snd_reg     <= '0;
            valid_reg   <= '0;
        end else if (cmd.exec) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            rty_reg     <= rty_next;
            snd_reg     <= snd_next;
            if (clr) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[gidx_reg] <= 1'b1;
            end
        end
    end

    // Burst pointer over the groups
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bidx_reg <= '0;
        end else if (cmd.exec) begin
            bidx_reg <= '0;
        end else if (cmd.bout) begin
            bidx_reg <= bidx_reg + 1'b1;
        end
    end

    // Result register: load a single result or one characterization entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((cmd.exec && !emit) || cmd.bout) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && !emit) begin
            o_act_reg   <= act;
            o_phase_reg <= phase_next;
            o_idx_reg   <= '0;
            o_sum_reg   <= '0;
            o_snd_reg   <= snd_next;
            o_last_reg  <= 1'b1;
            o_wk_reg    <= wk;
        end else if (cmd.bout) begin
            o_act_reg   <= ACT_CHAR;
            o_phase_reg <= phase_reg;
            o_idx_reg   <= bidx_reg;
            o_sum_reg   <= sum_rd;
            o_snd_reg   <= snd_reg;
            o_last_reg  <= sts.burst_last;
            o_wk_reg    <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_act_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {5'b0, o_wk_reg, o_snd_reg, o_sum_reg, o_idx_reg, o_phase_reg};

    assign sts.out_free   = !m_valid_reg || m_tready;
    assign sts.emit       = emit;
    assign sts.burst_last = (bidx_reg == GIDX_LAST);

    // Restart leaves every group reading as zero
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && op_reg == OP_RESTART) |=> (valid_reg == '0))
        else $error("sum store not cleared by restart");

    // A characterization entry goes out as a characterization transfer
    a_bout_char: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bout |=> (m_tvalid && m_tuser == ACT_CHAR))
        else $error("burst entry not presented as characterization");

    // Sending the characterization starts the burst at group zero in wait for response
    a_emit_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && emit) |=> (phase_reg == PH_WAIT_RSP && bidx_reg == '0))
        else $error("characterization burst started in wrong state");

endmodule

@@ rtl/core/sems_ctrl.sv @@
// Controller: sequences capture, execution and the characterization burst.
module sems_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output sems_pkg::sems_cmd_t  cmd,
    input  sems_pkg::sems_sts_t  sts
);
    import sems_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_BRD  = 4'b0100,
        ST_BOUT = 4'b1000
    } sems_seq_t;

    sems_seq_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = sts.emit ? ST_BRD : ST_IDLE;
                end
            end
            ST_BRD: begin
                cmd.brd    = 1'b1;
                state_next = ST_BOUT;
            end
            ST_BOUT: begin
                if (sts.out_free) begin
                    cmd.bout   = 1'b1;
                    state_next = sts.burst_last ? ST_IDLE : ST_BRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A captured item is always executed next
    a_capture_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("capture not followed by execution");

    // Hold the item while the result register is occupied
    a_exec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && !sts.out_free) |=> (state_reg == ST_EXEC))
        else $error("item dropped while output stalled");

    // The burst ends after the last group
    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.bout && sts.burst_last) |=> (state_reg == ST_IDLE))
        else $error("burst did not end on last group");

endmodule

@@ rtl/core/slac_evse_match_sequencer_top.sv @@
// Top level of the SLAC EVSE match sequencer.
// Usage:
//   s_* channel takes one item per transfer: a 1 ms tick, one element of a
//   classified frame, or a session restart. tuser = {msg_ok, msg_kind, op},
//   tlast = last group of a profile frame.
//   m_* channel returns the results. Most items give one status result; a
//   match request in wait-for-match gives a match confirm; the settle
//   deadline and each response resend give a run of 58 characterization
//   entries (sums of the group store), tlast on the last one.
//   cfg_* writes one configuration register per transfer; write only while
//   the block is idle. cfg_ready is always high.
// Timing: the sum store is read at the edge that accepts an item; the update and
//   the result load follow in the execute state, once the output register is free.
//   The next item is taken only after that and after any characterization run, which
//   reads each entry with a registered read, then loads it into the output register.
// Reset (aresetn low, synchronous) restores the register defaults, enters
//   wait-for-start and marks all sums as zero; no clearing sweep is needed.
// When the receiver stalls the result is held and one more item may be
//   accepted; it then waits until the output register frees.
module slac_evse_match_sequencer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sems_pkg::IN_DATA_W-1:0]    s_tdata,  // group_value[7:0], group_index[13:8],
                                                        // validated[14], window_expired[15]
    input  logic [sems_pkg::IN_USER_W-1:0]    s_tuser,  // op[1:0], msg_kind[4:2], msg_ok[5]
    input  logic                              s_tlast,  // group_last
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sems_pkg::OUT_DATA_W-1:0]   m_tdata,  // phase_now[2:0], entry_index[8:3],
                                                        // entry_sum[20:9], sound_count[25:21],
                                                        // wrong_key[26], zero[31:27]
    output logic [sems_pkg::OUT_USER_W-1:0]   m_tuser,  // action[1:0]
    output logic                              m_tlast,  // run_last
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sems_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sems_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sems_pkg::*;

    sems_cmd_t cmd;
    sems_sts_t sts;

    // Register writes are taken in any cycle
    assign cfg_ready = 1'b1;

    sems_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sems_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ tb/tb_slac_evse_match_sequencer_top.sv @@
// Self-checking testbench of the SLAC EVSE match sequencer: directed and random sessions.
module tb_slac_evse_match_sequencer_top;
    import sems_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          ITEM_TARGET    = 270;
    localparam int          QUIET_AFTER    = 220;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [2:0]  KIND_OTHER     = 3'd0;
    localparam logic [2:0]  KIND_RESERVED  = 3'd7;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;
    localparam logic [11:0] SUM_MAX        = 12'hFFF;
    localparam logic [4:0]  SND_MAX        = 5'd31;
    localparam int          MODE_HIGH      = 0;
    localparam int          MODE_LOW       = 1;
    localparam int          MODE_RANDOM    = 2;

    // One input transfer, unpacked from tdata, tuser and tlast
    typedef struct packed {
        logic [1:0] op;
        logic [2:0] kind;
        logic       ok;
        logic [7:0] gval;
        logic [5:0] gidx;
        logic       glast;
        logic       vdone;
        logic       wexp;
    } slac_item_t;

    // One result transfer
    typedef struct packed {
        logic [1:0]  act;
        logic [2:0]  phase_now;
        logic [5:0]  idx;
        logic [11:0] entry_sum;
        logic [4:0]  snd;
        logic        last;
        logic        wk;
    } slac_result_t;

    // Tracks the matching session and holds the results still owed by the block
    class slac_session_tracker;
        logic [15:0]  start_to, sound_to, settle_to, rsp_to, match_to;
        logic [2:0]   rty_max;
        logic [4:0]   snd_need;
        logic         key_bad;
        sems_phase_t  cur_phase;
        logic [15:0]  ticks;
        logic [2:0]   resends;
        logic [4:0]   sounds;
        logic [11:0]  group_acc [GROUPS];
        slac_result_t results_due [$];
        int           fails;

        function new();
            start_to  = 16'd400;
            sound_to  = 16'd600;
            settle_to = 16'd45;
            rsp_to    = 16'd200;
            match_to  = 16'd10000;
            rty_max   = 3'd2;
            snd_need  = 5'd10;
            key_bad   = 1'b0;
            fails     = 0;
            clear_session();
        endfunction

        function void clear_session();
            cur_phase = PH_WAIT_START;
            ticks     = '0;
            resends   = '0;
            sounds    = '0;
            foreach (group_acc[i]) group_acc[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_START_TO:  start_to  = val;
                REG_SOUND_TO:  sound_to  = val;
                REG_SETTLE:    settle_to = val;
                REG_RSP_TO:    rsp_to    = val;
                REG_MATCH_TO:  match_to  = val;
                REG_MAX_RTY:   rty_max   = val[2:0];
                REG_SND_NEED:  snd_need  = val[4:0];
                REG_FORCE_KEY: key_bad   = val[0];
                default: ;
            endcase
        endfunction

        function void move_to(sems_phase_t p);
            cur_phase = p;
            ticks     = '0;
        endfunction

        function void queue_result(logic [1:0] act, logic [5:0] idx, logic [11:0] s,
                                   logic last, logic wk);
            slac_result_t r;
            r.act       = act;
            r.phase_now = cur_phase;
            r.idx       = idx;
            r.entry_sum = s;
            r.snd       = sounds;
            r.last      = last;
            r.wk        = wk;
            results_due.push_back(r);
        endfunction

        // Apply one accepted item and queue the results it causes
        function void take_item(slac_item_t it);
            int   acc;
            logic send_char;
            logic send_confirm;
            send_char    = 1'b0;
            send_confirm = 1'b0;
            if (it.op == OP_RESTART) begin
                clear_session();
            end else if (it.op == OP_TICK && cur_phase <= PH_WAIT_MATCH) begin
                if (ticks != CNT_MAX)
                    ticks++;
                case (cur_phase)
                    PH_WAIT_START: if (ticks >= start_to) move_to(PH_FAILED);
                    PH_SOUNDING:   if (ticks >= sound_to) move_to(PH_SETTLE);
                    PH_SETTLE: begin
                        if (ticks >= settle_to) begin
                            move_to(PH_WAIT_RSP);
                            send_char = 1'b1;
                        end
                    end
                    PH_WAIT_RSP: begin
                        if (ticks >= rsp_to) begin
                            if (resends >= rty_max) begin
                                move_to(PH_FAILED);
                            end else begin
                                resends++;
                                ticks     = '0;
                                send_char = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (ticks >= match_to || (it.vdone && it.wexp))
                            move_to(PH_FAILED);
                    end
                endcase
            end else if (it.op == OP_FRAME && it.ok) begin
                if (cur_phase == PH_WAIT_START && it.kind == KIND_START) begin
                    // a start that arrives after the deadline is dropped
                    if (ticks < start_to)
                        move_to(PH_SOUNDING);
                end else if (cur_phase == PH_SOUNDING && it.kind == KIND_PROFILE) begin
                    if (it.gidx < GROUPS) begin
                        acc = group_acc[it.gidx] + it.gval;
                        group_acc[it.gidx] = (acc > SUM_MAX) ? SUM_MAX : acc[11:0];
                    end
                    if (it.glast) begin
                        if (sounds != SND_MAX)
                            sounds++;
                        if (sounds >= snd_need)
                            move_to(PH_SETTLE);
                    end
                end else if (cur_phase == PH_WAIT_RSP && it.kind == KIND_RESPONSE) begin
                    move_to(PH_WAIT_MATCH);
                end else if (cur_phase == PH_WAIT_MATCH && it.kind == KIND_MATCH) begin
                    move_to(PH_MATCHED);
                    send_confirm = 1'b1;
                end
            end
            if (send_char) begin
                for (int g = 0; g < GROUPS; g++)
                    queue_result(ACT_CHAR, GIDX_W'(g), group_acc[g], g == GROUPS - 1, 1'b0);
            end else if (send_confirm) begin
                queue_result(ACT_CONFIRM, '0, '0, 1'b1, key_bad);
            end else begin
                queue_result(ACT_STATUS, '0, '0, 1'b1, 1'b0);
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                fails++;
            end
        endfunction

        // Compare one accepted result with the oldest one owed
        function void check_result(logic [OUT_USER_W-1:0] act, logic last,
                                   logic [OUT_DATA_W-1:0] data);
            slac_result_t want;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none got action %0d data %h",
                         $time, act, data);
                fails++;
                return;
            end
            want = results_due.pop_front();
            cmp_field("action", want.act, act);
            cmp_field("phase_now", want.phase_now, data[2:0]);
            cmp_field("entry_index", want.idx, data[8:3]);
            cmp_field("entry_sum", want.entry_sum, data[20:9]);
            cmp_field("sound_count", want.snd, data[25:21]);
            cmp_field("wrong_key", want.wk, data[26]);
            cmp_field("pad", '0, data[31:27]);
            cmp_field("run_last", want.last, last);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    slac_session_tracker tracker;
    logic gaps_on      = 1'b1;
    logic stalls_on    = 1'b1;
    int   items_sent   = 0;
    int   quiet_cycles = 0;

    slac_evse_match_sequencer_top DUT (.*);

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Check results and watch for a stalled run
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tuser, m_tlast, m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stall the result channel in random bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic slac_item_t rand_item();
        logic [31:0] r;
        slac_item_t  it;
        r  = $urandom;
        it = r[$bits(slac_item_t)-1:0];
        return it;
    endfunction

    function automatic slac_item_t op_item(logic [1:0] op);
        slac_item_t it;
        it    = rand_item();
        it.op = op;
        return it;
    endfunction

    function automatic slac_item_t tick_item(logic vd, logic we);
        slac_item_t it;
        it       = op_item(OP_TICK);
        it.vdone = vd;
        it.wexp  = we;
        return it;
    endfunction

    function automatic slac_item_t frame_item(logic [2:0] kind, logic ok);
        slac_item_t it;
        it      = op_item(OP_FRAME);
        it.kind = kind;
        it.ok   = ok;
        return it;
    endfunction

    function automatic slac_item_t profile_item(logic [7:0] v, logic [5:0] g, logic lst);
        slac_item_t it;
        it       = frame_item(KIND_PROFILE, 1'b1);
        it.gval  = v;
        it.gidx  = g;
        it.glast = lst;
        return it;
    endfunction

    function automatic logic [15:0] pick_limit(int lo, int hi);
        return ($urandom_range(0, 9) == 0) ? CNT_MAX : 16'($urandom_range(lo, hi));
    endfunction

    // Present one item, with an optional gap in front, and hold until the transfer
    task automatic push_item(input slac_item_t it, input logic counted);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {it.wexp, it.vdone, it.gidx, it.gval};
        s_tuser  = {it.ok, it.kind, it.op};
        s_tlast  = it.glast;
        do @(posedge aclk); while (!s_tready);
        tracker.take_item(it);
        if (counted)
            items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_regs(input logic [15:0] st, sn, se, rs, ma,
                             input logic [2:0] rt, input logic [4:0] nd, input logic kb);
        write_reg(REG_START_TO, st);
        write_reg(REG_SOUND_TO, sn);
        write_reg(REG_SETTLE, se);
        write_reg(REG_RSP_TO, rs);
        write_reg(REG_MATCH_TO, ma);
        write_reg(REG_MAX_RTY, 16'(rt));
        write_reg(REG_SND_NEED, 16'(nd));
        write_reg(REG_FORCE_KEY, 16'(kb));
    endtask

    // Stop sending and let every owed result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.results_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // One session: fresh settings, restart, then mostly well-formed traffic with noise
    task automatic run_session(input int mode);
        logic [15:0] st, sn, se, rs, ma;
        logic [2:0]  rt;
        logic [4:0]  nd;
        logic        kb;
        logic        heavy;
        int          steps;
        int          cap;
        int          parts;
        logic [7:0]  v;
        logic [5:0]  g;
        heavy = (mode == MODE_HIGH);
        if (mode == MODE_HIGH) begin
            st = CNT_MAX; sn = CNT_MAX; se = 16'($urandom_range(0, 3));
            rs = CNT_MAX; ma = CNT_MAX; rt = 3'd7; nd = 5'd16; kb = 1'b1;
        end else if (mode == MODE_LOW) begin
            st = 16'd1; sn = 16'd1; se = 16'd0; rs = 16'd1; ma = 16'd1;
            rt = 3'd0; nd = 5'd1; kb = 1'b0;
        end else begin
            st = pick_limit(1, 8);
            sn = pick_limit(2, 12);
            se = pick_limit(0, 4);
            rs = pick_limit(1, 4);
            ma = pick_limit(1, 6);
            rt = 3'($urandom_range(0, 7));
            nd = 5'($urandom_range(1, 16));
            kb = 1'($urandom_range(0, 1));
        end
        wait_idle();
        load_regs(st, sn, se, rs, ma, rt, nd, kb);
        gaps_on   = (items_sent < QUIET_AFTER) && ($urandom_range(0, 2) != 0);
        stalls_on = (items_sent < QUIET_AFTER) && ($urandom_range(0, 2) != 0);
        push_item(op_item(OP_RESTART), 1'b1);
        cap   = heavy ? 120 : 45;
        steps = 0;
        while (steps < cap && tracker.cur_phase < PH_MATCHED) begin
            steps++;
            if ($urandom_range(0, 9) == 0) begin
                push_item(rand_item(), 1'b1);
            end else begin
                case (tracker.cur_phase)
                    PH_WAIT_START: begin
                        if ($urandom_range(0, 1) == 0)
                            push_item(frame_item(KIND_START, $urandom_range(0, 7) != 0), 1'b1);
                        else
                            push_item(tick_item(1'($urandom), 1'($urandom)), 1'b1);
                    end
                    PH_SOUNDING: begin
                        if (!heavy && $urandom_range(0, 6) == 0) begin
                            push_item(tick_item(1'($urandom), 1'($urandom)), 1'b1);
                        end else begin
                            // one profile frame, group_last on its final element
                            parts = heavy ? $urandom_range(2, 4) : $urandom_range(1, 3);
                            for (int k = 0; k < parts; k++) begin
                                if (heavy) begin
                                    v = 8'($urandom_range(200, 255));
                                    g = 6'($urandom_range(0, 1));
                                end else begin
                                    v = 8'($urandom);
                                    g = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(GROUPS, 63))
                                                                    : 6'($urandom_range(0, GROUPS - 1));
                                end
                                push_item(profile_item(v, g, k == parts - 1), 1'b1);
                            end
                        end
                    end
                    PH_SETTLE: push_item(tick_item(1'($urandom), 1'($urandom)), 1'b1);
                    PH_WAIT_RSP: begin
                        if ($urandom_range(0, 4) < 3)
                            push_item(tick_item(1'($urandom), 1'($urandom)), 1'b1);
                        else
                            push_item(frame_item(KIND_RESPONSE, $urandom_range(0, 7) != 0), 1'b1);
                    end
                    default: begin
                        if ($urandom_range(0, 1) == 0)
                            push_item(tick_item(1'($urandom), 1'($urandom)), 1'b1);
                        else
                            push_item(frame_item(KIND_MATCH, $urandom_range(0, 7) != 0), 1'b1);
                    end
                endcase
            end
        end
        // poke the session once or twice more, closed or not
        repeat ($urandom_range(1, 2)) push_item(rand_item(), 1'b1);
    endtask

    initial begin
        slac_item_t it;
        int         sess;
        tracker = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: codes, field extremes and the named corner cases
        push_item(op_item(OP_UNUSED), 1'b1);
        push_item(tick_item(1'b1, 1'b1), 1'b1);
        wait_idle();
        load_regs(CNT_MAX, CNT_MAX, 16'd0, 16'd1, 16'd2, 3'd1, 5'd2, 1'b1);
        push_item(tick_item(1'b0, 1'b0), 1'b1);
        wait_idle();
        // shrink the start deadline below the elapsed count: late start
        write_reg(REG_START_TO, 16'd1);
        push_item(frame_item(KIND_START, 1'b1), 1'b1);
        push_item(tick_item(1'b0, 1'b0), 1'b1);
        push_item(op_item(OP_RESTART), 1'b1);
        push_item(frame_item(KIND_START, 1'b0), 1'b1);
        push_item(frame_item(KIND_OTHER, 1'b1), 1'b1);
        push_item(frame_item(KIND_RESERVED, 1'b1), 1'b1);
        push_item(frame_item(KIND_START, 1'b1), 1'b1);
        push_item(profile_item(8'hFF, 6'd0, 1'b0), 1'b1);
        push_item(profile_item(8'hFF, GIDX_LAST, 1'b0), 1'b1);
        push_item(profile_item(8'h00, 6'h3F, 1'b1), 1'b1);
        it    = profile_item(8'h80, 6'd42, 1'b1);
        it.ok = 1'b0;
        push_item(it, 1'b1);
        push_item(profile_item(8'h80, 6'd42, 1'b1), 1'b1);
        // characterization, one resend, then retries run out
        repeat (3) push_item(tick_item(1'b0, 1'b0), 1'b1);
        push_item(frame_item(KIND_MATCH, 1'b1), 1'b1);
        push_item(op_item(OP_RESTART), 1'b1);
        push_item(frame_item(KIND_START, 1'b1), 1'b1);
        push_item(profile_item(8'd200, 6'd5, 1'b1), 1'b1);
        push_item(profile_item(8'd7, 6'd5, 1'b1), 1'b1);
        push_item(tick_item(1'b0, 1'b0), 1'b1);
        push_item(frame_item(KIND_RESPONSE, 1'b1), 1'b1);
        push_item(tick_item(1'b1, 1'b0), 1'b1);
        push_item(frame_item(KIND_MATCH, 1'b1), 1'b1);
        push_item(tick_item(1'b0, 1'b0), 1'b1);

        // Random sessions under changing settings
        sess = 0;
        while (items_sent < ITEM_TARGET) begin
            run_session((sess % 6 == 0) ? MODE_HIGH : (sess % 6 == 1) ? MODE_LOW : MODE_RANDOM);
            sess++;
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (tracker.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
